@@ sv/tlvdp_pkg.sv @@
// Shared types and constants of the TLV datagram parser with XOR check.
// Used by the parser, the record queue and the top level; depends on nothing.
package tlvdp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;
  localparam int unsigned CFG_IDX_W  = 3;

  // Record kinds.
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_U8     = 3'd1;
  localparam logic [2:0] KIND_U16    = 3'd2;
  localparam logic [2:0] KIND_U32    = 3'd3;
  localparam logic [2:0] KIND_SSTART = 3'd4;
  localparam logic [2:0] KIND_SCHAR  = 3'd5;
  localparam logic [2:0] KIND_END    = 3'd6;

  // End record status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_CHECKSUM  = 2'd1;
  localparam logic [1:0] STAT_MALFORMED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CODE_STRING  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_U16     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_U32     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_U8      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_TARGET = 3'd4;

  typedef struct packed {
    logic [7:0] code_string;
    logic [7:0] code_u16;
    logic [7:0] code_u32;
    logic [7:0] code_u8;
    logic [7:0] check_target;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  version;
    logic [7:0]  flags;
    logic [7:0]  xor_field;
    logic [7:0]  trans_id;
    logic [31:0] user_id;
    logic [31:0] key_word;
    logic [15:0] function_code;
    logic [15:0] add_len;
    logic [7:0]  attr_id;
    logic [31:0] param_value;
    logic [1:0]  status;
  } rec_t;

  // Records produced by one accepted byte: count is 0, 1 or 2, in order rec0, rec1.
  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

@@ sv/tlvdp_parser.sv @@
// Byte parser: phase tracking, header assembly, parameter decode and XOR check.
// Depends on tlvdp_pkg.
module tlvdp_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  input  tlvdp_pkg::cfg_t  cfg,
  output tlvdp_pkg::push_t push
);
  import tlvdp_pkg::*;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_ID     = 6'b000010,
    PH_TYPE   = 6'b000100,
    PH_VALUE  = 6'b001000,
    PH_SLEN   = 6'b010000,
    PH_SCHAR  = 6'b100000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [63:0] hs0, hs0_next;
  logic [63:0] hs1, hs1_next;
  logic [31:0] value_accum, value_accum_next;
  logic [15:0] string_left, string_left_next;
  logic [7:0]  current_id, current_id_next;
  logic [2:0]  current_kind, current_kind_next;
  logic [7:0]  xor_accum, xor_accum_next;
  logic        error_seen, error_seen_next;

  rec_t main_rec;
  logic main_valid;
  rec_t end_rec;

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    hs0_next          = hs0;
    hs1_next          = hs1;
    value_accum_next  = value_accum;
    string_left_next  = string_left;
    current_id_next   = current_id;
    current_kind_next = current_kind;
    error_seen_next   = error_seen;
    xor_accum_next    = xor_accum ^ data_byte;
    main_rec          = '0;
    main_valid        = 1'b0;

    case (phase)
      PH_HEADER: begin
        if (!byte_count[3]) begin
          hs0_next = {hs0[55:0], data_byte};
        end else begin
          hs1_next = {hs1[55:0], data_byte};
        end
        if (byte_count == 4'd15) begin
          main_valid             = 1'b1;
          main_rec.record_kind   = KIND_HEADER;
          main_rec.version       = hs0_next[63:56];
          main_rec.flags         = hs0_next[55:48];
          main_rec.xor_field     = hs0_next[47:40];
          main_rec.trans_id      = hs0_next[39:32];
          main_rec.user_id       = hs0_next[31:0];
          main_rec.key_word      = hs1_next[63:32];
          main_rec.function_code = hs1_next[31:16];
          main_rec.add_len       = hs1_next[15:0];
          byte_count_next        = 4'd0;
          phase_next             = PH_ID;
        end else begin
          byte_count_next = byte_count + 4'd1;
        end
      end
      PH_TYPE: begin
        value_accum_next = '0;
        // First match wins when several codes are equal.
        if (data_byte == cfg.code_string) begin
          current_kind_next = KIND_SSTART;
          byte_count_next   = 4'd2;
          phase_next        = PH_SLEN;
        end else if (data_byte == cfg.code_u16) begin
          current_kind_next = KIND_U16;
          byte_count_next   = 4'd2;
          phase_next        = PH_VALUE;
        end else if (data_byte == cfg.code_u32) begin
          current_kind_next = KIND_U32;
          byte_count_next   = 4'd4;
          phase_next        = PH_VALUE;
        end else if (data_byte == cfg.code_u8) begin
          current_kind_next = KIND_U8;
          byte_count_next   = 4'd1;
          phase_next        = PH_VALUE;
        end else begin
          error_seen_next = 1'b1;
          phase_next      = PH_ID;
        end
      end
      PH_VALUE: begin
        value_accum_next = {value_accum[23:0], data_byte};
        byte_count_next  = byte_count - 4'd1;
        if (byte_count_next == 4'd0) begin
          main_valid           = 1'b1;
          main_rec.record_kind = current_kind;
          main_rec.attr_id     = current_id;
          main_rec.param_value = value_accum_next;
          phase_next           = PH_ID;
        end
      end
      PH_SLEN: begin
        value_accum_next = {16'd0, value_accum[7:0], data_byte};
        byte_count_next  = byte_count - 4'd1;
        if (byte_count_next == 4'd0) begin
          main_valid           = 1'b1;
          main_rec.record_kind = KIND_SSTART;
          main_rec.attr_id     = current_id;
          main_rec.param_value = value_accum_next;
          string_left_next     = value_accum_next[15:0];
          phase_next           = (value_accum_next[15:0] == 16'd0) ? PH_ID : PH_SCHAR;
        end
      end
      PH_SCHAR: begin
        main_valid           = 1'b1;
        main_rec.record_kind = KIND_SCHAR;
        main_rec.attr_id     = current_id;
        main_rec.param_value = {24'd0, data_byte};
        string_left_next     = string_left - 16'd1;
        if (string_left_next == 16'd0) begin
          phase_next = PH_ID;
        end
      end
      default: begin
        current_id_next = data_byte;
        phase_next      = PH_TYPE;
      end
    endcase

    // End record; checksum failure takes priority over malformed.
    end_rec             = '0;
    end_rec.record_kind = KIND_END;
    if (xor_accum_next != cfg.check_target) begin
      end_rec.status = STAT_CHECKSUM;
    end else if (error_seen_next || (phase_next != PH_ID)) begin
      end_rec.status = STAT_MALFORMED;
    end else begin
      end_rec.status = STAT_OK;
    end

    push = '0;
    if (in_fire) begin
      if (last_byte) begin
        push.count = {1'b0, main_valid} + 2'd1;
        push.rec0  = main_valid ? main_rec : end_rec;
        push.rec1  = end_rec;
      end else begin
        push.count = {1'b0, main_valid};
        push.rec0  = main_rec;
      end
    end

    // A finished datagram returns the parser to its reset state.
    if (last_byte) begin
      phase_next        = PH_HEADER;
      byte_count_next   = '0;
      hs0_next          = '0;
      hs1_next          = '0;
      value_accum_next  = '0;
      string_left_next  = '0;
      current_id_next   = '0;
      current_kind_next = '0;
      xor_accum_next    = '0;
      error_seen_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_count   <= '0;
      hs0          <= '0;
      hs1          <= '0;
      value_accum  <= '0;
      string_left  <= '0;
      current_id   <= '0;
      current_kind <= '0;
      xor_accum    <= '0;
      error_seen   <= 1'b0;
    end else if (in_fire) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      hs0          <= hs0_next;
      hs1          <= hs1_next;
      value_accum  <= value_accum_next;
      string_left  <= string_left_next;
      current_id   <= current_id_next;
      current_kind <= current_kind_next;
      xor_accum    <= xor_accum_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

@@ sv/tlvdp_rec_fifo.sv @@
// Small record queue between the parser and the output channel; takes up to
// two records per cycle, hands out one on out_ready. Uses tlvdp_pkg.
module tlvdp_rec_fifo (
  input  logic             clk,
  input  logic             rst,
  input  tlvdp_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output tlvdp_pkg::rec_t  head
);
  import tlvdp_pkg::*;

  rec_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  // Room for two records, the most one byte can produce.
  assign room      = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.rec0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

@@ sv/tlv_datagram_parser_xor_check_unit.sv @@
// Top level of the TLV datagram parser with XOR check: configuration registers,
// byte parser and record queue. Depends on tlvdp_pkg, tlvdp_parser, tlvdp_rec_fifo.
//
// Usage:
//   Input channel (in_valid/in_ready, data_byte, last_byte) carries one datagram
//   byte per transaction, last_byte marking the final byte. Output channel
//   (out_valid/out_ready plus the record fields) carries one record per
//   transaction: a header record after byte 16, parameter, string start and
//   string character records, and an end record with a status after the last
//   byte. Fields that do not belong to a record's kind read as zero.
//   A record produced by an accepted byte is registered into the record queue
//   and offered on the output once the records ahead of it have left. The
//   input takes one byte per cycle while in_ready is high; a last byte that
//   also yields a header, parameter or string record gives two records.
//   in_ready is low while the four-entry record queue holds three or more
//   records, so a stalled receiver stops the input once three records wait;
//   a last byte taken with two records queued can fill all four entries.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
//   next edge and should only happen while the block is idle. Synchronous
//   reset restores the default codes and target and empties the queue.
module tlv_datagram_parser_xor_check_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  record_kind,
  output logic [7:0]  version,
  output logic [7:0]  flags,
  output logic [7:0]  xor_field,
  output logic [7:0]  trans_id,
  output logic [31:0] user_id,
  output logic [31:0] key_word,
  output logic [15:0] function_code,
  output logic [15:0] add_len,
  output logic [7:0]  attr_id,
  output logic [31:0] param_value,
  output logic [1:0]  status
);
  import tlvdp_pkg::*;

  cfg_t  cfg;
  push_t push;
  rec_t  head;
  logic  in_fire;

  assign in_fire = in_valid && in_ready;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_string  <= 8'd0;
      cfg.code_u16     <= 8'd1;
      cfg.code_u32     <= 8'd2;
      cfg.code_u8      <= 8'd3;
      cfg.check_target <= 8'd17;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CODE_STRING:  cfg.code_string  <= cfg_data;
        REG_CODE_U16:     cfg.code_u16     <= cfg_data;
        REG_CODE_U32:     cfg.code_u32     <= cfg_data;
        REG_CODE_U8:      cfg.code_u8      <= cfg_data;
        REG_CHECK_TARGET: cfg.check_target <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-byte parse: updates the datagram state and produces up to two records.
  tlvdp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg       (cfg),
    .push      (push)
  );

  // Record queue feeding the output channel.
  tlvdp_rec_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign record_kind   = head.record_kind;
  assign version       = head.version;
  assign flags         = head.flags;
  assign xor_field     = head.xor_field;
  assign trans_id      = head.trans_id;
  assign user_id       = head.user_id;
  assign key_word      = head.key_word;
  assign function_code = head.function_code;
  assign add_len       = head.add_len;
  assign attr_id       = head.attr_id;
  assign param_value   = head.param_value;
  assign status        = head.status;

`ifndef SYNTHESIS
  // The queue is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("record offered right after reset");

  // Only end records carry a nonzero status.
  a_status_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (record_kind != KIND_END)) |-> (status == STAT_OK))
    else $error("status set on a record that is not an end record");

  // A last byte always leaves at least one record queued at the next cycle.
  a_last_gives_record: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_byte) |=> out_valid)
    else $error("no record after the last byte of a datagram");

  // A byte taken by the parser produces at most two records.
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> (push.count != 2'd3))
    else $error("parser produced an impossible record count");
`endif

endmodule
